// File: sv/incremental_pi_speed_loop_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the incremental PI speed loop
// Concurrent assertion wrappers used by the speed loop RTL. Defining
// NO_ASSERTIONS removes every assertion from the build.
// ----------------------------------------------------------------------------
`ifndef INCREMENTAL_PI_SPEED_LOOP_MACROS_SVH
`define INCREMENTAL_PI_SPEED_LOOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// A property that must hold at every clock edge outside reset.
`define IPSL_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: assertion failed");
// A consequence that must hold in the cycle after its cause.
`define IPSL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define IPSL_ASSERT(lbl, clk, rstn, prop)
`define IPSL_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: sv/ipsl_pkg.sv
// ----------------------------------------------------------------------------
// Speed loop package
// Request and result types, register map and drive limits shared by the
// incremental PI speed loop modules.
// ----------------------------------------------------------------------------
package ipsl_pkg;

  localparam int SPEED_W = 16;
  localparam int ERR_W   = 17;
  localparam int DRIVE_W = 11;
  localparam int GAIN_W  = 16;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX_V = 11'sd999;
  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN_V = -11'sd999;

  localparam logic [GAIN_W-1:0] ERROR_GAIN_RST = 16'd1062;
  localparam logic [GAIN_W-1:0] DELTA_GAIN_RST = 16'd307;

  // Register index, taken from paddr[2].
  localparam logic REG_ERROR_GAIN = 1'b0;
  localparam logic REG_DELTA_GAIN = 1'b1;

  typedef struct packed {
    logic                      channel;
    logic signed [SPEED_W-1:0] target_speed;
    logic signed [SPEED_W-1:0] measured_speed;
  } in_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive_value;
    logic                      at_limit;
  } out_t;

  typedef struct packed {
    logic [GAIN_W-1:0] error_gain;
    logic [GAIN_W-1:0] delta_gain;
  } gains_t;

endpackage

// File: sv/ipsl_regs.sv
// ----------------------------------------------------------------------------
// Speed loop gain registers
// APB-style write and read access to the two Q-format loop gains.
// ----------------------------------------------------------------------------
module ipsl_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ipsl_pkg::ADDR_W-1:0]  paddr,
  input  logic [ipsl_pkg::DATA_W-1:0]  pwdata,
  output logic [ipsl_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output ipsl_pkg::gains_t             gains_o
);

  ipsl_pkg::gains_t gains_q;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q.error_gain <= ipsl_pkg::ERROR_GAIN_RST;
      gains_q.delta_gain <= ipsl_pkg::DELTA_GAIN_RST;
    end else if (wr_en) begin
      case (paddr[2])
        ipsl_pkg::REG_ERROR_GAIN: begin
          gains_q.error_gain <= pwdata[ipsl_pkg::GAIN_W-1:0];
        end
        ipsl_pkg::REG_DELTA_GAIN: begin
          gains_q.delta_gain <= pwdata[ipsl_pkg::GAIN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      ipsl_pkg::REG_ERROR_GAIN: begin
        prdata = {{(ipsl_pkg::DATA_W-ipsl_pkg::GAIN_W){1'b0}}, gains_q.error_gain};
      end
      ipsl_pkg::REG_DELTA_GAIN: begin
        prdata = {{(ipsl_pkg::DATA_W-ipsl_pkg::GAIN_W){1'b0}}, gains_q.delta_gain};
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  assign gains_o = gains_q;

endmodule

// File: sv/ipsl_calc.sv
// ----------------------------------------------------------------------------
// Speed loop arithmetic
// Forms the speed error, the incremental PI sum, truncation toward zero and
// the clamp to the drive limits for one request.
// ----------------------------------------------------------------------------
module ipsl_calc #(
  parameter int GAIN_FRAC_BITS = 8
) (
  input  ipsl_pkg::in_t                            req_i,
  input  ipsl_pkg::gains_t                         gains_i,
  input  logic signed [ipsl_pkg::DRIVE_W-1:0]      drive_i,
  input  logic signed [ipsl_pkg::ERR_W-1:0]        prev_err_i,
  output ipsl_pkg::out_t                           res_o,
  output logic signed [ipsl_pkg::ERR_W-1:0]        err_o
);

  localparam int DIFF_W = ipsl_pkg::ERR_W + 1;
  localparam int PE_W   = ipsl_pkg::GAIN_W + 1 + ipsl_pkg::ERR_W;
  localparam int PD_W   = ipsl_pkg::GAIN_W + 1 + DIFF_W;
  localparam int SUM_W  = PD_W + 2;
  localparam int Q_W    = SUM_W - GAIN_FRAC_BITS;
  localparam int ACC_PAD = SUM_W - ipsl_pkg::DRIVE_W - GAIN_FRAC_BITS;

  localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(ipsl_pkg::DRIVE_MAX_V);
  localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(ipsl_pkg::DRIVE_MIN_V);

  logic signed [ipsl_pkg::ERR_W-1:0]  err;
  logic signed [DIFF_W-1:0]           diff;
  logic signed [PE_W-1:0]             prod_e;
  logic signed [PD_W-1:0]             prod_d;
  logic signed [SUM_W-1:0]            acc_scaled;
  logic signed [SUM_W-1:0]            sum;
  logic signed [SUM_W-1:0]            biased;
  logic signed [Q_W-1:0]              q;

  assign err  = $signed({req_i.target_speed[ipsl_pkg::SPEED_W-1], req_i.target_speed})
              - $signed({req_i.measured_speed[ipsl_pkg::SPEED_W-1], req_i.measured_speed});
  assign diff = $signed({err[ipsl_pkg::ERR_W-1], err})
              - $signed({prev_err_i[ipsl_pkg::ERR_W-1], prev_err_i});

  // Gains are unsigned, so each gets a zero sign bit before the signed product.
  assign prod_e = $signed({1'b0, gains_i.error_gain}) * err;
  assign prod_d = $signed({1'b0, gains_i.delta_gain}) * diff;

  assign acc_scaled = {{ACC_PAD{drive_i[ipsl_pkg::DRIVE_W-1]}}, drive_i,
                       {GAIN_FRAC_BITS{1'b0}}};

  assign sum = acc_scaled
             + {{(SUM_W-PE_W){prod_e[PE_W-1]}}, prod_e}
             + {{(SUM_W-PD_W){prod_d[PD_W-1]}}, prod_d};

  // Truncation toward zero: negative sums are biased up by one less than the
  // scale before the arithmetic shift.
  assign biased = sum + $signed({{(SUM_W-GAIN_FRAC_BITS){1'b0}},
                                 {GAIN_FRAC_BITS{sum[SUM_W-1]}}});
  assign q = biased[SUM_W-1:GAIN_FRAC_BITS];

  always_comb begin
    if (q > Q_MAX) begin
      res_o.drive_value = ipsl_pkg::DRIVE_MAX_V;
      res_o.at_limit    = 1'b1;
    end else if (q < Q_MIN) begin
      res_o.drive_value = ipsl_pkg::DRIVE_MIN_V;
      res_o.at_limit    = 1'b1;
    end else begin
      res_o.drive_value = q[ipsl_pkg::DRIVE_W-1:0];
      res_o.at_limit    = 1'b0;
    end
  end

  assign err_o = err;

endmodule

// File: sv/incremental_pi_speed_loop.sv
// ----------------------------------------------------------------------------
// Incremental PI speed loop
// Per-channel incremental PI controller producing clamped PWM drive values.
// ----------------------------------------------------------------------------
// Each request names a motor channel and carries a target and a measured
// speed. The block forms the error e = target - measured and adds
// delta_gain * (e - previous e) + error_gain * e to that channel's stored
// drive value, with both gains unsigned and GAIN_FRAC_BITS fraction bits. The
// sum is truncated toward zero, clamped to +/-999, stored back and returned
// together with a flag that is set when the clamp acted. A channel number at
// or beyond NUM_CHANNELS wraps. The block accepts one request per clock cycle
// while results are taken, and returns each result as follows: a request is held in
// an input register, the arithmetic runs in one pass to the result register,
// and the channel's drive value and last error are written back at the same
// edge, so requests for the same channel may follow each other in adjacent
// cycles. The result register lets a new request enter while a finished
// result is still waiting to be taken. The gains are written through the
// APB-style port at byte addresses 0 (error gain) and 4 (delta gain).
// ----------------------------------------------------------------------------
`include "incremental_pi_speed_loop_macros.svh"

module incremental_pi_speed_loop #(
  parameter int NUM_CHANNELS   = 2,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Request channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  ipsl_pkg::in_t                in_data_i,
  // Result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output ipsl_pkg::out_t               out_data_o,
  // Configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ipsl_pkg::ADDR_W-1:0]  paddr,
  input  logic [ipsl_pkg::DATA_W-1:0]  pwdata,
  output logic [ipsl_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  ipsl_pkg::gains_t gains;

  // Input register.
  logic             s1_valid_q, s1_valid_d;
  ipsl_pkg::in_t    s1_data_q;
  logic             in_fire;
  logic             s1_fire;
  logic [CH_W-1:0]  s1_ch;

  // Result register.
  logic             out_valid_q, out_valid_d;
  ipsl_pkg::out_t   out_data_q;

  // Per-channel loop state.
  logic signed [ipsl_pkg::DRIVE_W-1:0] drive_q    [NUM_CHANNELS];
  logic signed [ipsl_pkg::ERR_W-1:0]   prev_err_q [NUM_CHANNELS];

  ipsl_pkg::out_t                      calc_res;
  logic signed [ipsl_pkg::ERR_W-1:0]   calc_err;

  ipsl_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .gains_o (gains)
  );

  // The request in the input register moves on whenever the result register
  // is empty or is being emptied in this cycle.
  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  // With a single channel every request maps onto it.
  assign s1_ch = (NUM_CHANNELS > 1) ? CH_W'(s1_data_q.channel) : '0;

  ipsl_calc #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_calc (
    .req_i      (s1_data_q),
    .gains_i    (gains),
    .drive_i    (drive_q[s1_ch]),
    .prev_err_i (prev_err_q[s1_ch]),
    .res_o      (calc_res),
    .err_o      (calc_err)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_data_q <= in_data_i;
    end
    if (s1_fire) begin
      out_data_q <= calc_res;
    end
  end

  // The loop state is written back at the edge where the result is captured,
  // so the next request for the same channel already sees it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        drive_q[i]    <= '0;
        prev_err_q[i] <= '0;
      end
    end else if (s1_fire) begin
      drive_q[s1_ch]    <= calc_res.drive_value;
      prev_err_q[s1_ch] <= calc_err;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A returned drive value never leaves the clamp range.
  `IPSL_ASSERT(a_drive_range, clk_i, rst_ni, !out_valid_o || ((out_data_o.drive_value <= ipsl_pkg::DRIVE_MAX_V) && (out_data_o.drive_value >= ipsl_pkg::DRIVE_MIN_V)))
  // The limit flag is only raised with a drive value sitting on a limit.
  `IPSL_ASSERT(a_limit_value, clk_i, rst_ni, !(out_valid_o && out_data_o.at_limit) || (out_data_o.drive_value == ipsl_pkg::DRIVE_MAX_V) || (out_data_o.drive_value == ipsl_pkg::DRIVE_MIN_V))
  // A request leaving the input register always lands in the result register.
  `IPSL_ASSERT_NEXT(a_result_follows, clk_i, rst_ni, s1_fire, out_valid_q)
  // Requests are only refused when both registers are full and the result stalls.
  `IPSL_ASSERT(a_ready_only_stalled, clk_i, rst_ni, in_ready_o || (s1_valid_q && out_valid_q && !out_ready_i))

endmodule

// File: tb/incremental_pi_speed_loop_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Incremental PI speed loop testbench
// Drives speed requests into both motor channels and checks every returned
// drive value and limit flag against a cycle-free PI model or a typed result.
// A table of directed requests comes first, then phases of random requests,
// each under its own pair of gains written through the configuration port.
// ----------------------------------------------------------------------------
module incremental_pi_speed_loop_tb;

  // Package types and constants used throughout the bench.
  typedef ipsl_pkg::in_t  in_t;
  typedef ipsl_pkg::out_t out_t;

  localparam int SPEED_W = ipsl_pkg::SPEED_W;
  localparam int ERR_W   = ipsl_pkg::ERR_W;
  localparam int DRIVE_W = ipsl_pkg::DRIVE_W;
  localparam int GAIN_W  = ipsl_pkg::GAIN_W;
  localparam int DATA_W  = ipsl_pkg::DATA_W;
  localparam int ADDR_W  = ipsl_pkg::ADDR_W;

  localparam logic REG_ERROR_GAIN = ipsl_pkg::REG_ERROR_GAIN;
  localparam logic REG_DELTA_GAIN = ipsl_pkg::REG_DELTA_GAIN;

  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX_V = ipsl_pkg::DRIVE_MAX_V;
  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN_V = ipsl_pkg::DRIVE_MIN_V;

  localparam logic [GAIN_W-1:0] ERROR_GAIN_RST = ipsl_pkg::ERROR_GAIN_RST;
  localparam logic [GAIN_W-1:0] DELTA_GAIN_RST = ipsl_pkg::DELTA_GAIN_RST;

  localparam int  NUM_CH     = 2;
  localparam int  FRAC_BITS  = 8;
  localparam int  HALF_CYCLE = 6;
  localparam int  IDLE_PCT   = 14;
  localparam int  HOLD_OFF   = 60;
  localparam int  N_PHASES   = 10;
  localparam int  PHASE_REQS = 133;
  localparam int  N_ROWS     = 23;

  // The two register addresses, one word apart.
  localparam logic [ADDR_W-1:0] ERROR_GAIN_ADDR = {REG_ERROR_GAIN, 2'b00};
  localparam logic [ADDR_W-1:0] DELTA_GAIN_ADDR = {REG_DELTA_GAIN, 2'b00};

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid;
  logic                in_ready;
  in_t                 in_data;
  logic                out_valid;
  logic                out_ready;
  out_t                out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // Model state: the gains as last written and the per-channel loop state.
  logic [GAIN_W-1:0]         error_gain_q;
  logic [GAIN_W-1:0]         delta_gain_q;
  logic signed [DRIVE_W-1:0] drive_acc [NUM_CH];
  logic signed [ERR_W-1:0]   last_error [NUM_CH];

  out_t expected_drives [$];
  int   mismatch_count = 0;

  // Handshake pacing shared between the stimulus and the result sink.
  bit   no_idle   = 1'b0;
  bit   stall_req = 1'b0;
  int   stall_left = 0;

  // One row of the directed table. Where typed is set the expected result is
  // written out by hand; every row is also run through the model so that the
  // loop state stays in step.
  typedef struct {
    bit                        set_gains;
    logic [GAIN_W-1:0]         eg;
    logic [GAIN_W-1:0]         dg;
    logic                      ch;
    logic signed [SPEED_W-1:0] tgt;
    logic signed [SPEED_W-1:0] meas;
    bit                        typed;
    logic signed [DRIVE_W-1:0] drv;
    logic                      lim;
  } speed_row_t;

  // The first rows run under the reset gains (1062 and 307, about 4.15 and
  // 1.2). Full-scale errors of both signs saturate the drive, and a return to
  // zero error after a full-scale step swings it to the other rail through
  // the change-of-error term. A steady error of zero holds exactly -999 with
  // the flag clear. With a unity error gain and no delta gain the drive moves
  // by the error alone, which lands exactly on both rails (flag clear) and one
  // count beyond them (flag set). A gain of one half shows that odd negative
  // sums are truncated toward zero and not rounded down. The remaining rows
  // try zero and full-scale gains with alternating bit patterns.
  speed_row_t speed_plan [N_ROWS] = '{
    '{1'b0, 16'd0,     16'd0,     1'b0, 16'sd0,      16'sd0,      1'b1, 11'sd0,   1'b0},
    '{1'b0, 16'd0,     16'd0,     1'b0, 16'sh7FFF,   16'sh8000,   1'b1, DRIVE_MAX_V, 1'b1},
    '{1'b0, 16'd0,     16'd0,     1'b1, 16'sh8000,   16'sh7FFF,   1'b1, DRIVE_MIN_V, 1'b1},
    '{1'b0, 16'd0,     16'd0,     1'b0, 16'sd0,      16'sd0,      1'b1, DRIVE_MIN_V, 1'b1},
    '{1'b0, 16'd0,     16'd0,     1'b1, 16'sd100,    16'sd90,     1'b1, DRIVE_MAX_V, 1'b1},
    '{1'b0, 16'd0,     16'd0,     1'b1, 16'sh8000,   16'sh8000,   1'b0, 11'sd0,   1'b0},
    '{1'b0, 16'd0,     16'd0,     1'b0, 16'sh7FFF,   16'sh7FFF,   1'b1, DRIVE_MIN_V, 1'b0},
    '{1'b1, 16'd256,   16'd0,     1'b0, 16'sd1998,   16'sd0,      1'b1, DRIVE_MAX_V, 1'b0},
    '{1'b0, 16'd0,     16'd0,     1'b0, 16'sd1,      16'sd0,      1'b1, DRIVE_MAX_V, 1'b1},
    '{1'b0, 16'd0,     16'd0,     1'b0, -16'sd1998,  16'sd0,      1'b1, DRIVE_MIN_V, 1'b0},
    '{1'b0, 16'd0,     16'd0,     1'b0, -16'sd1,     16'sd0,      1'b1, DRIVE_MIN_V, 1'b1},
    '{1'b0, 16'd0,     16'd0,     1'b0, 16'sd999,    16'sd0,      1'b1, 11'sd0,   1'b0},
    '{1'b1, 16'd128,   16'd0,     1'b0, -16'sd3,     16'sd0,      1'b1, -11'sd1,  1'b0},
    '{1'b0, 16'd0,     16'd0,     1'b0, 16'sd0,      16'sd3,      1'b1, -11'sd2,  1'b0},
    '{1'b0, 16'd0,     16'd0,     1'b0, 16'sd3,      16'sd0,      1'b1, 11'sd0,   1'b0},
    '{1'b1, 16'd0,     16'hFFFF,  1'b1, 16'sd5,      16'sd9,      1'b0, 11'sd0,   1'b0},
    '{1'b0, 16'd0,     16'd0,     1'b1, 16'sh7FFF,   16'sh8000,   1'b0, 11'sd0,   1'b0},
    '{1'b0, 16'd0,     16'd0,     1'b0, 16'sh8000,   16'sh7FFF,   1'b0, 11'sd0,   1'b0},
    '{1'b1, 16'hFFFF,  16'hFFFF,  1'b0, 16'sd1,      16'sd0,      1'b0, 11'sd0,   1'b0},
    '{1'b0, 16'd0,     16'd0,     1'b1, -16'sd1,     16'sd0,      1'b0, 11'sd0,   1'b0},
    '{1'b0, 16'd0,     16'd0,     1'b0, 16'sh5555,   16'shAAAA,   1'b0, 11'sd0,   1'b0},
    '{1'b0, 16'd0,     16'd0,     1'b1, 16'shAAAA,   16'sh5555,   1'b0, 11'sd0,   1'b0},
    '{1'b1, 16'd0,     16'd0,     1'b0, 16'sd123,    -16'sd456,   1'b0, 11'sd0,   1'b0}
  };

  incremental_pi_speed_loop #(
    .NUM_CHANNELS   (NUM_CH),
    .GAIN_FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #HALF_CYCLE clk_i = ~clk_i;

  // Generous bound on the whole run; a correct run needs a small part of it.
  initial begin
    #3_000_000;
    $display("incremental_pi_speed_loop_tb: errors");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // One step of the speed loop. The stored drive is lifted to the gain
  // format, both products are added exactly, and the sum is divided back
  // down; signed division truncates toward zero, which is what is wanted.
  function automatic out_t next_drive(input in_t req);
    int unsigned ch;
    longint      err;
    longint      err_change;
    longint      scaled_sum;
    longint      drive;
    out_t        res;
    ch         = int'(req.channel) % NUM_CH;
    err        = longint'(req.target_speed) - longint'(req.measured_speed);
    err_change = err - longint'(last_error[ch]);
    scaled_sum = longint'(drive_acc[ch]) * (longint'(1) << FRAC_BITS)
               + longint'(delta_gain_q) * err_change
               + longint'(error_gain_q) * err;
    drive      = scaled_sum / (longint'(1) << FRAC_BITS);
    res.at_limit = 1'b1;
    if (drive > longint'(DRIVE_MAX_V)) begin
      drive = longint'(DRIVE_MAX_V);
    end else if (drive < longint'(DRIVE_MIN_V)) begin
      drive = longint'(DRIVE_MIN_V);
    end else begin
      res.at_limit = 1'b0;
    end
    res.drive_value = drive[DRIVE_W-1:0];
    drive_acc[ch]   = drive[DRIVE_W-1:0];
    last_error[ch]  = err[ERR_W-1:0];
    return res;
  endfunction

  // Offers one request, with a random gap in front of it, and holds it until
  // the block takes it. The expectation is queued at the accepting edge. The
  // task returns just after that edge, so the caller must either offer again
  // or lower valid at the very next falling edge.
  task automatic offer_request(input in_t req, input bit typed, input out_t typed_res);
    out_t res;
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    res = next_drive(req);
    expected_drives.push_back(typed ? typed_res : res);
  endtask

  // Stops offering and waits for every outstanding result, then lets the
  // pipeline settle before the port is touched.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (expected_drives.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // Setup cycle then access cycle; the transfer completes at the edge where
  // pready is seen high during the access cycle.
  task automatic apb_transfer(input logic wr, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] wdata,
                              output logic [DATA_W-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_gain(input logic [ADDR_W-1:0] addr, input logic [GAIN_W-1:0] want);
    logic [DATA_W-1:0] rd;
    apb_transfer(1'b0, addr, '0, rd);
    if (rd[GAIN_W-1:0] !== want)
      flag_mismatch($sformatf("gain at address %0d reads %0d, expected %0d",
                              addr, rd[GAIN_W-1:0], want));
  endtask

  // Writes both gains with junk in the upper bits, which the block must
  // drop, then reads them back.
  task automatic program_gains(input logic [GAIN_W-1:0] eg, input logic [GAIN_W-1:0] dg);
    logic [DATA_W-1:0] rd;
    apb_transfer(1'b1, ERROR_GAIN_ADDR, {16'($urandom), eg}, rd);
    apb_transfer(1'b1, DELTA_GAIN_ADDR, {16'($urandom), dg}, rd);
    error_gain_q = eg;
    delta_gain_q = dg;
    check_gain(ERROR_GAIN_ADDR, eg);
    check_gain(DELTA_GAIN_ADDR, dg);
  endtask

  // Mostly modest gains, so that the loop spends time off the rails, with
  // the extremes turning up now and then.
  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return GAIN_W'($urandom);
      3:       return GAIN_W'($urandom_range(4095));
      default: return GAIN_W'($urandom_range(511));
    endcase
  endfunction

  // Most requests track a target with a small error, as a running motor
  // would; the rest are full-range noise.
  function automatic in_t pick_request();
    in_t req;
    int  tgt;
    req.channel = 1'($urandom);
    if ($urandom_range(99) < 15) begin
      req.target_speed   = SPEED_W'($urandom);
      req.measured_speed = SPEED_W'($urandom);
    end else begin
      tgt = $urandom_range(6000) - 3000;
      req.target_speed   = SPEED_W'(tgt);
      req.measured_speed = SPEED_W'(tgt + $urandom_range(400) - 200);
    end
    return req;
  endfunction

  // Result sink. Ready idles at random except in the no-idle phase; when the
  // stimulus asks for a stall it is held low for a fixed stretch, counted
  // here, while requests keep coming so that the block backs up.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_req) begin
        stall_req  = 1'b0;
        stall_left = HOLD_OFF;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Every result taken is compared with the oldest expectation.
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_drives.size() == 0) begin
        flag_mismatch($sformatf("unexpected result: drive %0d limit %0b",
                                out_data.drive_value, out_data.at_limit));
      end else begin
        want = expected_drives.pop_front();
        if (out_data.drive_value !== want.drive_value)
          flag_mismatch($sformatf("drive value %0d, expected %0d",
                                  out_data.drive_value, want.drive_value));
        if (out_data.at_limit !== want.at_limit)
          flag_mismatch($sformatf("limit flag %0b, expected %0b (drive %0d)",
                                  out_data.at_limit, want.at_limit, want.drive_value));
      end
    end
  end

  initial begin
    in_t        req;
    out_t       typed_res;
    speed_row_t row;
    int         ph;
    int         k;

    rst_ni   <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;

    error_gain_q = ERROR_GAIN_RST;
    delta_gain_q = DELTA_GAIN_RST;
    for (k = 0; k < NUM_CH; k++) begin
      drive_acc[k]  = '0;
      last_error[k] = '0;
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // The gains must come out of reset at their defaults.
    check_gain(ERROR_GAIN_ADDR, ERROR_GAIN_RST);
    check_gain(DELTA_GAIN_ADDR, DELTA_GAIN_RST);

    // Directed table. A row that carries new gains first lets the block run
    // dry so that the write lands while it is idle.
    for (k = 0; k < N_ROWS; k++) begin
      row = speed_plan[k];
      if (row.set_gains) begin
        wait_drained();
        program_gains(row.eg, row.dg);
      end
      req.channel        = row.ch;
      req.target_speed   = row.tgt;
      req.measured_speed = row.meas;
      typed_res.drive_value = row.drv;
      typed_res.at_limit    = row.lim;
      offer_request(req, row.typed, typed_res);
    end

    // Random phases, each under fresh gains. The first restores the reset
    // values and the second uses both gains at full scale. One phase runs
    // with no idling on either side, and in another the sink stalls for a
    // long stretch while requests keep arriving.
    for (ph = 0; ph < N_PHASES; ph++) begin
      wait_drained();
      case (ph)
        0:       program_gains(ERROR_GAIN_RST, DELTA_GAIN_RST);
        1:       program_gains('1, '1);
        default: program_gains(pick_gain(), pick_gain());
      endcase
      no_idle = (ph == 4);
      for (k = 0; k < PHASE_REQS; k++) begin
        if (ph == 2 && k == 30)
          stall_req = 1'b1;
        offer_request(pick_request(), 1'b0, typed_res);
      end
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("incremental_pi_speed_loop_tb: clean");
    end else begin
      $display("incremental_pi_speed_loop_tb: errors");
    end
    $finish;
  end

endmodule
